@@ sv/assert_macros.svh @@
// assertion macros shared by the encoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge out of reset
`define RLE_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define RLE_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`else

`define RLE_ASSERT_ALWAYS(label, cond, msg)
`define RLE_ASSERT_IMPLIES(label, ante, cons, msg)

`endif

`endif

@@ sv/rle_pkg.sv @@
// shared types, constants and decimal helpers of the run-length encoder
package rle_pkg;

  localparam int unsigned RUN_LEN_W   = 16;
  localparam logic [RUN_LEN_W-1:0] MAX_RUN = 16'd65535;
  localparam int unsigned NUM_DIGITS  = 5;
  localparam int unsigned DIGIT_IDX_W = 3;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [7:0]  ASCII_ZERO  = 8'h30;

  typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;

  localparam bcd_t BCD_ONE = bcd_t'(1);
  localparam logic [DIGIT_IDX_W-1:0] ND_ONE = DIGIT_IDX_W'(1);

  // one closed run: byte, decimal count and number of significant digits
  typedef struct packed {
    logic [7:0]             ch;
    bcd_t                   digits;
    logic [DIGIT_IDX_W-1:0] nd;
  } rle_run_t;

  // everything that one input request causes
  typedef struct packed {
    rle_run_t run_a;
    rle_run_t run_b;
    logic     b_valid;
    logic     eom;
  } rle_entry_t;

  // push side of the queue
  typedef struct packed {
    logic       push;
    rle_entry_t entry;
  } rle_push_t;

  // decimal increment, carry rippling through the digits
  function automatic bcd_t bcd_inc(input bcd_t d);
    bcd_t r;
    logic c;
    r = d;
    c = 1'b1;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (c) begin
        if (d[i] == 4'd9) begin
          r[i] = 4'd0;
        end else begin
          r[i] = d[i] + 4'd1;
          c = 1'b0;
        end
      end
    end
    return r;
  endfunction

  // number of significant digits, at least one
  function automatic logic [DIGIT_IDX_W-1:0] digits_used(input bcd_t d);
    logic [DIGIT_IDX_W-1:0] r;
    r = ND_ONE;
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (d[i] != 4'd0) begin
        r = DIGIT_IDX_W'(i + 1);
      end
    end
    return r;
  endfunction

endpackage

@@ sv/rle_front.sv @@
// front end: accepts bytes, tracks the open run and queues runs to emit
module rle_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_data_byte,
  input  logic              in_end_of_message,
  input  logic              q_full,
  output rle_pkg::rle_push_t q_push
);
  import rle_pkg::*;

  `include "assert_macros.svh"

  logic                   open_r, open_nxt;
  logic [7:0]             char_r, char_nxt;
  logic [RUN_LEN_W-1:0]   len_r, len_nxt;
  bcd_t                   bcd_r, bcd_nxt;
  logic [DIGIT_IDX_W-1:0] nd_r, nd_nxt;

  logic                   accept;
  logic                   close;
  rle_run_t               closed_run;
  rle_run_t               cur_run;
  logic [RUN_LEN_W-1:0]   cur_len;
  bcd_t                   inc_bcd;

  // stall only while the queue has no room
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign inc_bcd  = bcd_inc(bcd_r);

  // classify the byte: extend, start or close-and-start
  always_comb begin
    close          = 1'b0;
    cur_run.ch     = in_data_byte;
    cur_run.digits = BCD_ONE;
    cur_run.nd     = ND_ONE;
    cur_len        = RUN_LEN_W'(1);
    if (open_r) begin
      if (in_data_byte == char_r && len_r < MAX_RUN) begin
        cur_run.ch     = char_r;
        cur_run.digits = inc_bcd;
        cur_run.nd     = digits_used(inc_bcd);
        cur_len        = len_r + RUN_LEN_W'(1);
      end else begin
        close = 1'b1;
      end
    end
  end

  assign closed_run.ch     = char_r;
  assign closed_run.digits = bcd_r;
  assign closed_run.nd     = nd_r;

  // queue entry: closed run first, then the flushed run
  always_comb begin
    q_push.push          = accept && (close || in_end_of_message);
    q_push.entry.eom     = in_end_of_message;
    if (close) begin
      q_push.entry.run_a   = closed_run;
      q_push.entry.run_b   = cur_run;
      q_push.entry.b_valid = in_end_of_message;
    end else begin
      q_push.entry.run_a   = cur_run;
      q_push.entry.run_b   = cur_run;
      q_push.entry.b_valid = 1'b0;
    end
  end

  // run state update
  always_comb begin
    open_nxt = open_r;
    char_nxt = char_r;
    len_nxt  = len_r;
    bcd_nxt  = bcd_r;
    nd_nxt   = nd_r;
    if (accept) begin
      if (in_end_of_message) begin
        open_nxt = 1'b0;
        char_nxt = 8'h00;
        len_nxt  = '0;
        bcd_nxt  = '0;
        nd_nxt   = '0;
      end else begin
        open_nxt = 1'b1;
        char_nxt = cur_run.ch;
        len_nxt  = cur_len;
        bcd_nxt  = cur_run.digits;
        nd_nxt   = cur_run.nd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      char_r <= 8'h00;
      len_r  <= '0;
      bcd_r  <= '0;
      nd_r   <= '0;
    end else begin
      open_r <= open_nxt;
      char_r <= char_nxt;
      len_r  <= len_nxt;
      bcd_r  <= bcd_nxt;
      nd_r   <= nd_nxt;
    end
  end

  // an open run always has a nonzero length and at least one digit
  `RLE_ASSERT_ALWAYS(a_open_nonzero, !open_r || (len_r != '0 && nd_r != '0), "open run empty")

endmodule

@@ sv/rle_fifo.sv @@
// short queue of run entries between front and back end
module rle_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  rle_pkg::rle_push_t  q_push,
  output logic                q_full,
  input  logic                pop,
  output logic                q_vld,
  output rle_pkg::rle_entry_t q_head
);
  import rle_pkg::*;

  `include "assert_macros.svh"

  rle_entry_t             mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                   do_push;
  logic                   do_pop;

  assign q_full  = (cnt_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign q_vld   = (cnt_r != '0);
  assign q_head  = mem_r[rd_ptr_r];
  assign do_push = q_push.push && !q_full;
  assign do_pop  = pop && q_vld;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QUEUE_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QUEUE_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QUEUE_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QUEUE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_push.entry;
    end
  end

  // a push is never offered into a full queue
  `RLE_ASSERT_ALWAYS(a_no_push_full, !(q_push.push && q_full), "push into full queue")
  // fill count stays within the depth
  `RLE_ASSERT_ALWAYS(a_cnt_range, cnt_r <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue count overflow")

endmodule

@@ sv/rle_back.sv @@
// back end: walks a queued entry and sends run byte and count digits
module rle_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_vld,
  input  rle_pkg::rle_entry_t q_head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                out_last_of_burst,
  output logic                out_message_done
);
  import rle_pkg::*;

  `include "assert_macros.svh"

  rle_entry_t             cur_r, cur_nxt;
  logic                   cur_vld_r, cur_vld_nxt;
  logic                   slot_r, slot_nxt;
  logic [DIGIT_IDX_W-1:0] pos_r, pos_nxt;
  logic                   out_vld_r, out_vld_nxt;
  logic [7:0]             byte_r, byte_nxt;
  logic                   last_r, last_nxt;
  logic                   done_r, done_nxt;

  rle_run_t               run_sel;
  logic [DIGIT_IDX_W-1:0] dig_idx;
  logic [7:0]             byte_now;
  logic                   run_end;
  logic                   entry_end;
  logic                   adv;
  logic                   emit;

  // byte at the current position of the current run
  assign run_sel   = slot_r ? cur_r.run_b : cur_r.run_a;
  assign dig_idx   = run_sel.nd - pos_r;
  assign byte_now  = (pos_r == '0) ? run_sel.ch
                                   : (ASCII_ZERO | {4'h0, run_sel.digits[dig_idx]});
  assign run_end   = (pos_r == run_sel.nd);
  assign entry_end = run_end && (slot_r || !cur_r.b_valid);

  assign adv  = !out_vld_r || !out_stall;
  assign emit = adv && cur_vld_r;
  assign pop  = q_vld && (!cur_vld_r || (emit && entry_end));

  // sequencing through the entry and the output register
  always_comb begin
    cur_nxt     = cur_r;
    cur_vld_nxt = cur_vld_r;
    slot_nxt    = slot_r;
    pos_nxt     = pos_r;
    out_vld_nxt = adv ? cur_vld_r : out_vld_r;
    byte_nxt    = byte_r;
    last_nxt    = last_r;
    done_nxt    = done_r;
    if (emit) begin
      byte_nxt = byte_now;
      last_nxt = entry_end;
      done_nxt = entry_end && cur_r.eom;
      if (entry_end) begin
        cur_vld_nxt = q_vld;
        slot_nxt    = 1'b0;
        pos_nxt     = '0;
      end else if (run_end) begin
        slot_nxt = 1'b1;
        pos_nxt  = '0;
      end else begin
        pos_nxt = pos_r + DIGIT_IDX_W'(1);
      end
    end else if (!cur_vld_r) begin
      cur_vld_nxt = q_vld;
      slot_nxt    = 1'b0;
      pos_nxt     = '0;
    end
    if (pop) begin
      cur_nxt = q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      slot_r    <= 1'b0;
      pos_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      slot_r    <= slot_nxt;
      pos_r     <= pos_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    done_r <= done_nxt;
  end

  assign out_valid         = out_vld_r;
  assign out_byte          = byte_r;
  assign out_last_of_burst = last_r;
  assign out_message_done  = done_r;

  // the end of a message always closes a burst
  `RLE_ASSERT_ALWAYS(a_done_last, !(out_vld_r && done_r) || last_r, "done without last")
  // position never runs past the digits of the run
  `RLE_ASSERT_ALWAYS(a_pos_range, !cur_vld_r || pos_r <= run_sel.nd, "digit position overrun")

endmodule

@@ sv/run_length_encoder_decimal_counts.sv @@
// top level of the run-length encoder with decimal counts
//
//   channel   direction   handshake           payload
//   in        input       in_valid/in_stall   in_data_byte, in_end_of_message
//   out       output      out_valid/out_stall out_byte, out_last_of_burst, out_message_done
//
// input: one byte per cycle while the run queue (4 entries) has room
// output: one byte per cycle from the back end's output register while out_stall is low; a closed run
//   goes out as its byte followed by its count digits, so the back end sets the rate
// a byte that causes no emission still waits while the queue is full
// reset is synchronous, active low, and clears run state, queue and output valid
// out_stall holds the output register; in_stall rises only while the queue is full
module run_length_encoder_decimal_counts (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_message,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_of_burst,
  output logic       out_message_done
);
  import rle_pkg::*;

  rle_push_t  q_push;
  logic       q_full;
  logic       q_vld;
  logic       pop;
  rle_entry_t q_head;

  // classify bytes and track the open run
  rle_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .q_full            (q_full),
    .q_push            (q_push)
  );

  // queue between the two sides
  rle_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_full (q_full),
    .pop    (pop),
    .q_vld  (q_vld),
    .q_head (q_head)
  );

  // serialize run bytes and count digits
  rle_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_vld             (q_vld),
    .q_head            (q_head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_last_of_burst (out_last_of_burst),
    .out_message_done  (out_message_done)
  );

endmodule

@@ test/run_length_encoder_decimal_counts_tb.sv @@
// self-checking testbench for the run-length encoder with decimal counts
`timescale 1ns / 1ps

module run_length_encoder_decimal_counts_tb;
  import rle_pkg::MAX_RUN;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam logic [7:0] DIGIT_ZERO = 8'h30;

  // one encoded output byte with its flags
  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       done;
  } enc_byte_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_data_byte;
  logic       in_end_of_message;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_last_of_burst;
  logic       out_message_done;

  // encoder state mirrored by the predictor
  logic [7:0]  enc_char;
  logic [15:0] enc_len;
  logic        enc_active;

  enc_byte_t expected_bytes[$];
  enc_byte_t burst_bytes[$];

  int send_idle_pct;
  int recv_stall_pct;
  int long_hold_cycles;
  int mismatches;
  int cycle_count;

  run_length_encoder_decimal_counts dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_last_of_burst (out_last_of_burst),
    .out_message_done  (out_message_done)
  );

  // clock
  always #5 clk = ~clk;

  // run guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run_length_encoder_decimal_counts: mismatch");
      $finish;
    end
  end

  // receiver stall: long hold-off when requested, random otherwise
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (long_hold_cycles > 0) begin
      out_stall <= 1'b1;
      long_hold_cycles = long_hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // compare each accepted output byte with the oldest expected one
  always @(posedge clk) begin
    enc_byte_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        $error("out_byte: nothing expected, got %h", out_byte);
        mismatches++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte !== want.b) begin
          $error("out_byte: expected %h, got %h", want.b, out_byte);
          mismatches++;
        end
        if (out_last_of_burst !== want.last) begin
          $error("out_last_of_burst: expected %b, got %b", want.last, out_last_of_burst);
          mismatches++;
        end
        if (out_message_done !== want.done) begin
          $error("out_message_done: expected %b, got %b", want.done, out_message_done);
          mismatches++;
        end
      end
    end
  end

  // run byte followed by its length in decimal, most significant digit first
  function automatic void append_run(input logic [7:0] ch, input logic [15:0] len);
    logic [7:0] digit_chars[5];
    int n;
    int v;
    v = len;
    n = 0;
    burst_bytes.push_back('{ch, 1'b0, 1'b0});
    do begin
      digit_chars[n] = 8'(DIGIT_ZERO + v % 10);
      n++;
      v = v / 10;
    end while (v != 0);
    while (n > 0) begin
      n--;
      burst_bytes.push_back('{digit_chars[n], 1'b0, 1'b0});
    end
  endfunction

  // expected output bytes caused by one accepted request
  function automatic void predict_encoding(input logic [7:0] b, input logic eom);
    burst_bytes.delete();
    if (!enc_active) begin
      enc_char = b;
      enc_len = 16'd1;
      enc_active = 1'b1;
    end else if (b == enc_char && enc_len < MAX_RUN) begin
      enc_len = enc_len + 16'd1;
    end else begin
      append_run(enc_char, enc_len);
      enc_char = b;
      enc_len = 16'd1;
    end
    // end of message flushes the open run
    if (eom) begin
      append_run(enc_char, enc_len);
      burst_bytes[burst_bytes.size() - 1].done = 1'b1;
      enc_char = 8'h00;
      enc_len = 16'd0;
      enc_active = 1'b0;
    end
    if (burst_bytes.size() > 0) begin
      burst_bytes[burst_bytes.size() - 1].last = 1'b1;
    end
    foreach (burst_bytes[i]) begin
      expected_bytes.push_back(burst_bytes[i]);
    end
  endfunction

  // offer one request after a random gap and wait until it is taken
  task automatic send_byte(input logic [7:0] b, input logic eom);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_data_byte <= 8'($urandom);
      in_end_of_message <= 1'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_end_of_message <= eom;
    do begin
      @(posedge clk);
    end while (in_stall);
    predict_encoding(b, eom);
  endtask

  // random messages: mostly short runs, some long, bytes often repeated
  task automatic send_random_messages(input int n_items);
    int sent;
    int runs;
    int len;
    logic [7:0] ch;
    sent = 0;
    while (sent < n_items) begin
      runs = $urandom_range(1, 6);
      for (int r = 0; r < runs && sent < n_items; r++) begin
        if ($urandom_range(2) == 0) begin
          ch = 8'(8'h41 + $urandom_range(2));
        end else begin
          ch = 8'($urandom);
        end
        len = ($urandom_range(9) == 0) ? $urandom_range(13, 120) : $urandom_range(1, 12);
        // the last request of the phase also ends its message
        if (len > n_items - sent) begin
          len = n_items - sent;
        end
        for (int i = 0; i < len; i++) begin
          send_byte(ch, (i == len - 1) && ((r == runs - 1) || (sent + 1 == n_items)));
          sent++;
        end
      end
    end
  endtask

  // extremes of the byte, single-byte messages, runs ending on the flag
  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h41, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b1);
    send_byte(8'h43, 1'b0);
    send_byte(8'h43, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    // run of a digit character, count carries nothing yet
    repeat (9) send_byte(8'h30, 1'b0);
    send_byte(8'h31, 1'b1);
  endtask

  // counts across the one-, two- and three-digit boundaries
  task automatic test_count_widths();
    int lens[4];
    lens = '{9, 10, 99, 100};
    send_idle_pct = 0;
    recv_stall_pct = 0;
    foreach (lens[k]) begin
      repeat (lens[k]) send_byte(8'(8'h61 + k), 1'b0);
    end
    send_byte(8'h5A, 1'b1);
  endtask

  task automatic test_random_no_idle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_random_messages(30);
  endtask

  task automatic test_random_sender_idle();
    send_idle_pct = 58;
    recv_stall_pct = 0;
    send_random_messages(30);
  endtask

  task automatic test_random_receiver_stall();
    send_idle_pct = 0;
    recv_stall_pct = 58;
    send_random_messages(30);
  endtask

  task automatic test_random_both_idle();
    send_idle_pct = 36;
    recv_stall_pct = 36;
    send_random_messages(30);
  endtask

  // receiver holds off while single-byte messages keep coming, so the input stalls
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    long_hold_cycles = 300;
    repeat (25) send_byte(8'($urandom), 1'b1);
  endtask

  // stop offering and let every expected byte come out
  task automatic drain_outputs();
    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (expected_bytes.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = 8'h00;
    in_end_of_message = 1'b0;
    out_stall = 1'b0;
    enc_char = 8'h00;
    enc_len = 16'd0;
    enc_active = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    long_hold_cycles = 0;
    mismatches = 0;
    cycle_count = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_count_widths();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    test_backpressure();
    drain_outputs();

    if (mismatches == 0) begin
      $display("run_length_encoder_decimal_counts: match");
    end else begin
      $display("run_length_encoder_decimal_counts: mismatch");
    end
    $finish;
  end

endmodule
